// ----- hw/rtl/partitioned_index_scatter_unit_macros.svh -----
// Assertion macros shared by the partitioned index scatter unit RTL.
// Depends on nothing; the asserting modules must have clk and rst in scope.
`ifndef PARTITIONED_INDEX_SCATTER_UNIT_MACROS_SVH
`define PARTITIONED_INDEX_SCATTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PIS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PIS_ASSERT_IMPL(lbl, ante, cons, msg)
`define PIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/pis_pkg.sv -----
// Package for the partitioned index scatter unit: field widths, opcodes,
// controller state type and the command and status bundles. No dependencies.
package pis_pkg;

  localparam int OP_W     = 2;
  localparam int QUBIT_W  = 7;
  localparam int BLOCK_W  = 4;
  localparam int LOCAL_W  = 6;
  localparam int SIZE_W   = 7;
  localparam int HALF_W   = 64;
  localparam int INDEX_W  = 2 * HALF_W;
  localparam int INDEX_AW = 7;
  localparam int RESULT_W = 64;
  localparam int CFG_W    = 8;
  localparam int MAP_W    = BLOCK_W + LOCAL_W;

  localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_SIZE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_W-1:0] NUM_QUBITS_RESET = 8'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic wr_map;
    logic wr_size;
    logic start;
    logic issue;
    logic load_out;
  } pis_cmd_t;

  typedef struct packed {
    logic skip;
    logic last_issue;
    logic out_busy;
  } pis_sts_t;

endpackage

// ----- hw/rtl/pis_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module pis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/pis_datapath.sv -----
// Datapath of the partitioned index scatter unit: mapping and size tables,
// qubit walk counter, accumulator and output register. Uses pis_pkg, pis_ram.
module pis_datapath #(
  parameter int MAX_QUBITS = 128,
  parameter int MAX_BLOCKS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pis_pkg::pis_cmd_t             cmd,
  output pis_pkg::pis_sts_t             sts,
  input  logic [pis_pkg::CFG_W-1:0]     num_qubits,
  input  logic [pis_pkg::QUBIT_W-1:0]   qubit,
  input  logic [pis_pkg::BLOCK_W-1:0]   block,
  input  logic [pis_pkg::LOCAL_W-1:0]   local_pos,
  input  logic [pis_pkg::SIZE_W-1:0]    size_value,
  input  logic [pis_pkg::HALF_W-1:0]    index_low,
  input  logic [pis_pkg::HALF_W-1:0]    index_high,
  input  logic                          reverse,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pis_pkg::RESULT_W-1:0]  local_index
);
  import pis_pkg::*;

  localparam int NW = $clog2(MAX_QUBITS + 1);
  localparam int QA = $clog2(MAX_QUBITS);
  localparam int BA = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [INDEX_W-1:0]  idx;
  logic [BLOCK_W-1:0]  blk;
  logic                rev;
  logic [NW-1:0]       n;
  logic [NW-1:0]       p;
  logic [NW-1:0]       p_d;
  logic                d_valid;
  logic [RESULT_W-1:0] acc;

  logic [NW-1:0]       n_eff;
  logic                qubit_ok;
  logic                block_ok;
  logic [NW-1:0]       g;
  logic [MAP_W-1:0]    map_rd;
  logic [SIZE_W-1:0]   size_rd;
  logic [BLOCK_W-1:0]  map_blk;
  logic [LOCAL_W-1:0]  map_loc;
  logic [SIZE_W-1:0]   mirror;
  logic                rev_ok;
  logic                hit;
  logic [LOCAL_W-1:0]  bit_pos;

  // The qubit count saturates at the table depth.
  assign n_eff = (num_qubits > CFG_W'(MAX_QUBITS)) ? NW'(MAX_QUBITS) : NW'(num_qubits);
  assign qubit_ok = {1'b0, qubit} < CFG_W'(MAX_QUBITS);
  assign block_ok = SIZE_W'(block) < SIZE_W'(MAX_BLOCKS);

  pis_ram #(.WIDTH(MAP_W), .DEPTH(MAX_QUBITS)) u_map_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_map && qubit_ok && block_ok),
    .wr_addr (QA'(qubit)),
    .wr_data ({block, local_pos}),
    .rd_en   (cmd.issue),
    .rd_addr (QA'(g)),
    .rd_data (map_rd)
  );

  pis_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_BLOCKS)) u_size_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_size && block_ok),
    .wr_addr (BA'(block)),
    .wr_data (size_value),
    .rd_en   (cmd.start),
    .rd_addr (BA'(block)),
    .rd_data (size_rd)
  );

  // In reverse mode the walk visits the tables from the top qubit down.
  assign g = rev ? (n - NW'(1) - p) : p;

  assign map_blk = map_rd[MAP_W-1:LOCAL_W];
  assign map_loc = map_rd[LOCAL_W-1:0];
  assign mirror  = size_rd - SIZE_W'(1) - SIZE_W'(map_loc);
  assign rev_ok  = (size_rd != '0) && (SIZE_W'(map_loc) < size_rd) && !mirror[SIZE_W-1];
  assign bit_pos = rev ? mirror[LOCAL_W-1:0] : map_loc;
  assign hit     = d_valid && idx[INDEX_AW'(p_d)] && (map_blk == blk) && (!rev || rev_ok);

  assign sts.skip       = !block_ok || (n_eff == '0);
  assign sts.last_issue = (p == n - NW'(1));
  assign sts.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx <= {index_high, index_low};
      blk <= block;
      rev <= reverse;
      n   <= n_eff;
      p   <= '0;
      acc <= '0;
    end else begin
      if (cmd.issue) begin
        p   <= p + NW'(1);
        p_d <= p;
      end
      if (hit) begin
        acc <= acc | (RESULT_W'(1) << bit_pos);
      end
    end
    if (cmd.load_out) begin
      local_index <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      d_valid <= cmd.issue;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/pis_controller.sv -----
// Controller state machine of the partitioned index scatter unit.
// Uses pis_pkg and the assertion macros header.
`include "partitioned_index_scatter_unit_macros.svh"
module pis_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [pis_pkg::OP_W-1:0]   in_op,
  output logic                       in_ready,
  output pis_pkg::pis_cmd_t          cmd,
  input  pis_pkg::pis_sts_t          sts
);
  import pis_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_MAP:   cmd.wr_map = 1'b1;
            OP_SIZE:  cmd.wr_size = 1'b1;
            OP_QUERY: begin
              cmd.start  = 1'b1;
              state_next = sts.skip ? ST_FINISH : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `PIS_ASSERT_NEXT(a_query_starts, state == ST_IDLE && in_valid && in_op == OP_QUERY, state == ST_WALK || state == ST_FINISH, "query beat did not start a walk")
  `PIS_ASSERT_NEXT(a_walk_ends, state == ST_WALK && sts.last_issue, state == ST_DRAIN && !cmd.issue, "walk did not stop after the last qubit")
  `PIS_ASSERT_NEXT(a_finish_frees, state == ST_FINISH && !sts.out_busy, state == ST_IDLE && in_ready, "result load did not return to idle")

endmodule

// ----- hw/rtl/partitioned_index_scatter_unit.sv -----
// Timing: a query beat keeps the input busy while the walk visits n = min(num_qubits,
// MAX_QUBITS) qubits, then through drain and finish; the result is loaded at finish,
// later while the previous result still waits. A query that walks nothing goes straight
// to finish; table writes end at acceptance. Throughput: the walk visits one qubit per cycle.
// Reset: rst is synchronous, active high; control state clears, num_qubits returns
// to 128, the tables keep their contents and are undefined until written.
//
// Top level of the partitioned index scatter unit. Uses pis_pkg, pis_controller,
// pis_datapath and pis_ram.
module partitioned_index_scatter_unit #(
  parameter int MAX_QUBITS = 128,
  parameter int MAX_BLOCKS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // From bit 0 up: qubit[6:0], block[10:7], local_pos[16:11], size_value[23:17],
  // index_low[87:24], index_high[151:88].
  input  logic [151:0] s_tdata,
  // From bit 0 up: op[1:0], reverse[2].
  input  logic [2:0]   s_tuser,
  // Result stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // From bit 0 up: local_index[63:0].
  output logic [63:0]  m_tdata,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pis_pkg::*;

  logic [CFG_W-1:0] num_qubits;
  logic             cfg_write;
  pis_cmd_t         cmd;
  pis_sts_t         sts;

  // The only register, num_qubits, sits at byte address 0. pready is tied high,
  // so a write completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : 32'(num_qubits);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_qubits <= NUM_QUBITS_RESET;
    end else if (cfg_write) begin
      num_qubits <= pwdata[CFG_W-1:0];
    end
  end

  // The controller takes a beat only in its idle state. Table writes finish at
  // the accepting edge; a query walks the mapping table and then hands its
  // result to the output register, which may still hold the previous result
  // while the next beat is taken.
  pis_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser[1:0]),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pis_datapath #(
    .MAX_QUBITS (MAX_QUBITS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .num_qubits  (num_qubits),
    .qubit       (s_tdata[6:0]),
    .block       (s_tdata[10:7]),
    .local_pos   (s_tdata[16:11]),
    .size_value  (s_tdata[23:17]),
    .index_low   (s_tdata[87:24]),
    .index_high  (s_tdata[151:88]),
    .reverse     (s_tuser[2]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .local_index (m_tdata)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for partitioned_index_scatter_unit. It fills the mapping
// tables, then runs directed and random scatter queries against a local predictor.
// Depends on pis_pkg and the partitioned_index_scatter_unit RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pis_pkg::*;

  // Opcode that the block must ignore, and the byte address of num_qubits.
  localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
  localparam logic [2:0]      ADDR_NUM_QUBITS = 3'd0;
  localparam int TABLE_DEPTH  = 128;
  localparam int BLOCK_COUNT  = 16;
  // Settling wait after the queues empty, a little longer than the longest query walk.
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int NUM_PHASES   = 10;

  // One input beat, packed so that {s_tuser, s_tdata} maps onto it directly.
  typedef struct packed {
    logic            rev;
    logic [OP_W-1:0] op;
    logic [63:0]     idx_hi;
    logic [63:0]     idx_lo;
    logic [6:0]      size_value;
    logic [5:0]      local_pos;
    logic [3:0]      blk;
    logic [6:0]      qubit;
  } scatter_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  partitioned_index_scatter_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Beats waiting to be sent, and local_index values waiting to come back.
  scatter_beat_t pending_ops[$];
  logic [63:0]   expected_local_index[$];
  int            error_count = 0;

  // Predictor copy of the block's tables and of the qubit count register.
  logic [3:0] block_of_q[TABLE_DEPTH];
  logic [5:0] local_of_q[TABLE_DEPTH];
  logic [6:0] block_len[BLOCK_COUNT];
  logic [7:0] qubit_count = NUM_QUBITS_RESET;

  // Walks the active qubits and projects the set bits of the global index
  // that belong to the target block onto their local positions.
  function automatic logic [63:0] scatter_to_local(input logic [127:0] gidx,
                                                   input logic [3:0] blk,
                                                   input logic rev);
    logic [63:0] acc;
    int n;
    int p;
    int g;
    int pos;
    int len;
    acc = '0;
    n = (qubit_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(qubit_count);
    len = int'(block_len[blk]);
    for (p = 0; p < n; p++) begin
      if (!gidx[p]) continue;
      g = rev ? (n - 1 - p) : p;
      if (block_of_q[g] != blk) continue;
      pos = int'(local_of_q[g]);
      if (rev) begin
        // Mirroring needs a nonzero size and a position inside the block,
        // and the mirrored position must still fit in the 64-bit result.
        if (len == 0 || pos >= len) continue;
        pos = len - 1 - pos;
        if (pos > 63) continue;
      end
      acc[pos] = 1'b1;
    end
    return acc;
  endfunction

  function automatic logic [127:0] random_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Mixes dense, sparse, single-bit and extreme index patterns.
  function automatic logic [127:0] random_index();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return 128'(1) << $urandom_range(0, 127);
      3, 4: return random_wide() & random_wide() & random_wide();
      default: return random_wide();
    endcase
  endfunction

  // Every field random; callers overwrite the fields that matter for the op.
  function automatic scatter_beat_t random_beat(input logic [OP_W-1:0] op);
    scatter_beat_t b;
    b.rev        = 1'($urandom_range(0, 1));
    b.op         = op;
    b.idx_hi     = {$urandom, $urandom};
    b.idx_lo     = {$urandom, $urandom};
    b.size_value = 7'($urandom_range(0, 127));
    b.local_pos  = 6'($urandom_range(0, 63));
    b.blk        = 4'($urandom_range(0, 15));
    b.qubit      = 7'($urandom_range(0, 127));
    return b;
  endfunction

  task automatic push_map(input int q, input int blk, input int pos);
    scatter_beat_t b;
    b = random_beat(OP_MAP);
    b.qubit     = 7'(q);
    b.blk       = 4'(blk);
    b.local_pos = 6'(pos);
    pending_ops.insert(pending_ops.size(), b);
  endtask

  task automatic push_size(input int blk, input int len);
    scatter_beat_t b;
    b = random_beat(OP_SIZE);
    b.blk        = 4'(blk);
    b.size_value = 7'(len);
    pending_ops.insert(pending_ops.size(), b);
  endtask

  task automatic push_query(input logic [127:0] gidx, input int blk, input logic rev);
    scatter_beat_t b;
    b = random_beat(OP_QUERY);
    b.idx_lo = gidx[63:0];
    b.idx_hi = gidx[127:64];
    b.blk    = 4'(blk);
    b.rev    = rev;
    pending_ops.insert(pending_ops.size(), b);
  endtask

  // Host-style partition: a random permutation of all qubits dealt into
  // the given number of blocks, local positions counted up per block, then
  // every block size written. Now and then a size is deliberately off.
  task automatic build_partition(input int parts);
    int order[TABLE_DEPTH];
    int fill[BLOCK_COUNT];
    int i;
    int j;
    int t;
    int b;
    for (i = 0; i < TABLE_DEPTH; i++) order[i] = i;
    for (i = 0; i < BLOCK_COUNT; i++) fill[i] = 0;
    for (i = TABLE_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < TABLE_DEPTH; i++) begin
      b = $urandom_range(0, parts - 1);
      push_map(order[i], b, fill[b] % 64);
      fill[b]++;
    end
    for (i = 0; i < BLOCK_COUNT; i++) begin
      if ($urandom_range(0, 7) == 0) push_size(i, $urandom_range(0, 127));
      else push_size(i, (fill[i] > 127) ? 127 : fill[i]);
    end
  endtask

  // Holds the initial block until the sender has nothing left, every result
  // has come back, and a possible trailing table write has long finished.
  task automatic settle();
    while (pending_ops.size() != 0 || s_tvalid || expected_local_index.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; the register takes the value at the edge where
  // psel, penable and pwrite are all high (pready is always high).
  task automatic cfg_write(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NUM_QUBITS;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    qubit_count = value;
  endtask

  // Input driver: sends pending beats in bursts of random length with random
  // gaps between them; a burst may also end with no gap at all.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        {s_tuser, s_tdata} <= pending_ops.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: switches between always ready, mostly ready and mostly
  // stalled, each mode lasting a random stretch of cycles.
  int ready_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(30, 400);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Monitor: checks each result beat against the oldest prediction, and
  // feeds each accepted input beat through the predictor.
  always @(posedge clk) begin
    scatter_beat_t beat;
    logic [63:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_local_index.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
          error_count++;
        end else begin
          want = expected_local_index.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: local_index mismatch, expected %h, actual %h",
                     $time, want, m_tdata);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        beat = {s_tuser, s_tdata};
        case (beat.op)
          OP_MAP: begin
            block_of_q[beat.qubit] = beat.blk;
            local_of_q[beat.qubit] = beat.local_pos;
          end
          OP_SIZE: block_len[beat.blk] = beat.size_value;
          OP_QUERY:
            expected_local_index.insert(expected_local_index.size(),
                scatter_to_local({beat.idx_hi, beat.idx_lo}, beat.blk, beat.rev));
          default: ;
        endcase
      end
    end
  end

  // Global watchdog on the cycle count.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int settings[NUM_PHASES];
    int ph;
    int i;
    int r;
    int parts;
    int items;
    int value;
    scatter_beat_t b;
    settings = '{128, 1, 255, 64, 2, 127, 0, 200, 129, 33};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Define every table entry before the first query: qubit i goes to block
    // i mod 16 at local position i / 16, and every block holds eight qubits.
    for (i = 0; i < TABLE_DEPTH; i++) push_map(i, i % BLOCK_COUNT, i / BLOCK_COUNT);
    for (i = 0; i < BLOCK_COUNT; i++) push_size(i, 8);
    parts = BLOCK_COUNT;

    // Directed part, at the reset qubit count of 128.
    push_query('0, 0, 1'b0);
    push_query('1, 0, 1'b0);
    push_query('1, 15, 1'b1);
    // Only the upper half set: block 7 gets only its qubits from 64 up, at local positions 4 to 7.
    push_query({64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 7, 1'b0);
    push_query({64'd1, 64'd1}, 0, 1'b0);
    push_query({64'd1, 64'd1}, 0, 1'b1);
    // Unused opcode with every field at its maximum changes nothing.
    b = '1;
    b.op = OP_UNUSED;
    pending_ops.insert(pending_ops.size(), b);
    // A zero block size drops every bit in reverse mode but none forward.
    push_size(3, 0);
    push_query('1, 3, 1'b1);
    push_query('1, 3, 1'b0);
    // An oversized block mirrors its positions beyond bit 63.
    push_size(4, 127);
    push_query('1, 4, 1'b1);
    push_size(5, 64);
    push_map(127, 5, 63);
    push_query({64'h8000_0000_0000_0000, 64'd0}, 5, 1'b0);
    push_query({64'h8000_0000_0000_0000, 64'd0}, 5, 1'b1);
    push_map(0, 15, 0);
    push_query(128'd1, 15, 1'b1);
    // Local positions of block 6 reach 7, so most lie at or above size 2.
    push_size(6, 2);
    push_query('1, 6, 1'b1);
    settle();

    // Qubit counts above 128 saturate, zero walks nothing, one walks qubit 0.
    cfg_write(8'd255);
    push_query('1, 15, 1'b1);
    settle();
    cfg_write(8'd0);
    push_query('1, 0, 1'b0);
    settle();
    cfg_write(8'd1);
    push_query('1, 15, 1'b1);
    push_query('1, 15, 1'b0);

    // Random phases: each sets a qubit count and, every fourth phase, lays out
    // a fresh partition, then mixes queries with stray writes and noise.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      value = (ph == NUM_PHASES - 1) ? $urandom_range(1, 128) : settings[ph];
      cfg_write(8'(value));
      if (ph % 4 == 0) begin
        parts = $urandom_range(1, BLOCK_COUNT);
        build_partition(parts);
      end
      items = (value == 0) ? 20 : 40;
      repeat (items) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          push_query(random_index(),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, parts - 1),
                     1'($urandom_range(0, 1)));
        end else if (r < 84) begin
          push_map($urandom_range(0, 127), $urandom_range(0, parts - 1),
                   $urandom_range(0, 63));
        end else if (r < 94) begin
          push_size($urandom_range(0, 15),
                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 64));
        end else begin
          pending_ops.insert(pending_ops.size(), random_beat(OP_UNUSED));
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
